/* src/battery_pack_discharge_selector_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the battery pack discharge selector
// Concurrent checks that vanish from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BATTERY_PACK_DISCHARGE_SELECTOR_TOP_MACROS_SVH
`define BATTERY_PACK_DISCHARGE_SELECTOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BPDS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define BPDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define BPDS_ASSERT_SAME(label, clk, rst, ante, cons)
`define BPDS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* src/bpds_pkg.sv */
// ----------------------------------------------------------------------------
// bpds_pkg
// Types and codes shared by the discharge selector top level and its core.
// ----------------------------------------------------------------------------
`default_nettype none

package bpds_pkg;

   // fixed number of pack snapshot slots in an item
   localparam int MAX_PACKS = 3;

   // pack state codes
   localparam logic [2:0] ST_DISC        = 3'd0;
   localparam logic [2:0] ST_STANDBY     = 3'd1;
   localparam logic [2:0] ST_DISCHARGING = 3'd2;
   localparam logic [2:0] ST_CHARGING    = 3'd3;

   // register indexes
   localparam logic [1:0] CSR_MIN_VOLT_DIFF = 2'd0;
   localparam logic [1:0] CSR_MIN_DIS_CUR   = 2'd1;
   localparam logic [1:0] CSR_PORT_MASK     = 2'd2;
   localparam logic [1:0] CSR_SWITCH_EN     = 2'd3;

   typedef enum logic [2:0] {
      OP_PROCESS = 3'd0,
      OP_PAUSE   = 3'd1,
      OP_RESUME  = 3'd2,
      OP_FORCE   = 3'd3,
      OP_RELEASE = 3'd4,
      OP_DONE    = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_PAUSED   = 2'd1,
      STS_REJECTED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CMD_NONE      = 3'd0,
      CMD_SWITCH    = 3'd1,
      CMD_MERGE     = 3'd2,
      CMD_POWER_OFF = 3'd3,
      CMD_RELEASE   = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_FORCE_OK = 2'd1,
      EV_FORCE_LOST = 2'd2
   } event_type;

   typedef enum logic {
      PEND_MOVE      = 1'b0,
      PEND_POWER_OFF = 1'b1
   } pend_type;

   typedef struct packed {
      op_type             op;
      logic [1:0]         pack_id;
      logic               success;
      logic [2:0]         state_a;
      logic [2:0]         state_b;
      logic [2:0]         state_c;
      logic [15:0]        vol_a;
      logic [15:0]        vol_b;
      logic [15:0]        vol_c;
      logic signed [15:0] cur_a;
      logic signed [15:0] cur_b;
      logic signed [15:0] cur_c;
   } req_item_type;

   typedef struct packed {
      status_type status;
      cmd_type    cmd;
      logic [1:0] cmd_pack;
      event_type  event_res;
      logic [1:0] event_pack;
      logic [1:0] discharging_count;
      logic       busy_res;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] min_volt_diff;
      logic [15:0] min_discharge_current;
      logic [2:0]  port_enable_mask;
      logic        switch_enable;
   } cfg_type;

   typedef struct packed {
      logic       paused;
      logic       in_flight;
      logic       forced_valid;
      logic [1:0] forced_pack;
      pend_type   pending_kind;
   } ctl_state_type;

endpackage

`default_nettype wire

/* src/bpds_core.sv */
// ----------------------------------------------------------------------------
// bpds_core
// Decision logic for one item: result fields and next control state.
// ----------------------------------------------------------------------------
`default_nettype none

module bpds_core #(
   parameter int PACK_COUNT = 3
) (
   input  bpds_pkg::req_item_type  item,
   input  bpds_pkg::ctl_state_type cur_state,
   input  bpds_pkg::cfg_type       cfg,
   output bpds_pkg::rsp_item_type  result,
   output bpds_pkg::ctl_state_type next_state
);
   import bpds_pkg::*;

   logic [2:0]         st  [MAX_PACKS];
   logic [15:0]        vol [MAX_PACKS];
   logic signed [15:0] cur [MAX_PACKS];

   assign st[0]  = item.state_a;
   assign st[1]  = item.state_b;
   assign st[2]  = item.state_c;
   assign vol[0] = item.vol_a;
   assign vol[1] = item.vol_b;
   assign vol[2] = item.vol_c;
   assign cur[0] = item.cur_a;
   assign cur[1] = item.cur_b;
   assign cur[2] = item.cur_c;

   // forced path: state of the forced pack and first other discharging pack
   logic       fp_absent;
   logic [2:0] st_fp;
   logic       other_found;
   logic [1:0] other_pack;

   always_comb begin
      fp_absent   = (32'(cur_state.forced_pack) >= PACK_COUNT);
      st_fp       = ST_DISC;
      other_found = 1'b0;
      other_pack  = 2'd0;
      for (int i = 0; i < MAX_PACKS; i++) begin
         if (i < PACK_COUNT) begin
            if (cur_state.forced_pack == 2'(i)) begin
               st_fp = st[i];
            end else if (!other_found && st[i] == ST_DISCHARGING) begin
               other_found = 1'b1;
               other_pack  = 2'(i);
            end
         end
      end
   end

   // normal path: best standby pack, active voltage, current sum
   logic [15:0]        best_vol;
   logic [1:0]         best_pack;
   logic               best_found;
   logic [15:0]        act_vol;
   logic signed [17:0] cur_sum;
   logic [1:0]         dcount;

   always_comb begin
      best_vol   = 16'd0;
      best_pack  = 2'd0;
      best_found = 1'b0;
      act_vol    = 16'd0;
      cur_sum    = 18'sd0;
      dcount     = 2'd0;
      for (int i = 0; i < MAX_PACKS; i++) begin
         if (i < PACK_COUNT && st[i] != ST_DISC) begin
            if (st[i] == ST_DISCHARGING) dcount = dcount + 2'd1;
            if (st[i] == ST_STANDBY && best_vol < vol[i]) begin
               best_vol   = vol[i];
               best_pack  = 2'(i);
               best_found = 1'b1;
            end
            if (st[i] == ST_DISCHARGING || st[i] == ST_CHARGING) act_vol = vol[i];
            cur_sum = cur_sum + 18'(cur[i]);
         end
      end
   end

   // gap and current magnitude
   logic signed [16:0] diff;
   logic [16:0]        adiff;
   logic [17:0]        asum;
   logic               gap_small;
   logic               gap_large;
   logic               cur_low;

   always_comb begin
      diff      = $signed({1'b0, best_vol}) - $signed({1'b0, act_vol});
      adiff     = diff[16] ? 17'(-diff) : 17'(diff);
      asum      = cur_sum[17] ? 18'(-cur_sum) : 18'(cur_sum);
      gap_small = (adiff < {1'b0, cfg.min_volt_diff});
      gap_large = (diff > $signed({1'b0, cfg.min_volt_diff}));
      cur_low   = (asum < {2'b00, cfg.min_discharge_current});
   end

   // force admission checks
   logic [2:0] st_pid;
   logic       pid_ok;

   always_comb begin
      st_pid = ST_DISC;
      pid_ok = 1'b0;
      for (int i = 0; i < MAX_PACKS; i++) begin
         if (i < PACK_COUNT && item.pack_id == 2'(i)) begin
            st_pid = st[i];
            pid_ok = cfg.port_enable_mask[i];
         end
      end
   end

   // op dispatch
   rsp_item_type  res;
   ctl_state_type nxt;

   always_comb begin
      res            = '0;
      res.status     = STS_OK;
      res.cmd        = CMD_NONE;
      res.event_res  = EV_NONE;
      nxt            = cur_state;
      case (item.op)
         OP_PROCESS: begin
            if (cur_state.paused) begin
               res.status = STS_PAUSED;
            end else if (cur_state.forced_valid) begin
               if (cur_state.in_flight) begin
                  // controller busy: hold
               end else if (fp_absent || st_fp == ST_DISC) begin
                  res.event_res    = EV_FORCE_LOST;
                  res.event_pack   = cur_state.forced_pack;
                  nxt.forced_valid = 1'b0;
                  nxt.forced_pack  = 2'd0;
               end else if (st_fp != ST_DISCHARGING) begin
                  nxt.in_flight    = 1'b1;
                  nxt.pending_kind = PEND_MOVE;
                  res.cmd          = CMD_SWITCH;
                  res.cmd_pack     = cur_state.forced_pack;
               end else if (other_found) begin
                  nxt.in_flight    = 1'b1;
                  nxt.pending_kind = PEND_POWER_OFF;
                  res.cmd          = CMD_POWER_OFF;
                  res.cmd_pack     = other_pack;
               end
            end else begin
               res.discharging_count = dcount;
               if (!cur_state.in_flight && best_found) begin
                  if (gap_small) begin
                     nxt.in_flight    = 1'b1;
                     nxt.pending_kind = PEND_MOVE;
                     res.cmd          = CMD_MERGE;
                     res.cmd_pack     = best_pack;
                  end else if (gap_large && cur_low && cfg.switch_enable) begin
                     nxt.in_flight    = 1'b1;
                     nxt.pending_kind = PEND_MOVE;
                     res.cmd          = CMD_SWITCH;
                     res.cmd_pack     = best_pack;
                  end
               end
            end
         end
         OP_PAUSE: begin
            res.cmd       = CMD_RELEASE;
            nxt.in_flight = 1'b0;
            nxt.paused    = 1'b1;
         end
         OP_RESUME: begin
            nxt.paused = 1'b0;
         end
         OP_FORCE: begin
            if (cur_state.paused || !pid_ok || st_pid == ST_DISC) begin
               res.status = STS_REJECTED;
            end else if (cur_state.forced_valid && cur_state.forced_pack == item.pack_id &&
                         st_pid == ST_DISCHARGING) begin
               res.event_res  = EV_FORCE_OK;
               res.event_pack = item.pack_id;
            end else begin
               nxt.forced_valid = 1'b1;
               nxt.forced_pack  = item.pack_id;
            end
         end
         OP_RELEASE: begin
            if (cur_state.paused) begin
               res.status = STS_REJECTED;
            end else begin
               nxt.forced_valid = 1'b0;
               nxt.forced_pack  = 2'd0;
            end
         end
         OP_DONE: begin
            nxt.in_flight = 1'b0;
            if (cur_state.pending_kind == PEND_MOVE && item.success &&
                cur_state.forced_valid) begin
               res.event_res  = EV_FORCE_OK;
               res.event_pack = cur_state.forced_pack;
            end
         end
         default: begin
            // unknown op: nothing changes
         end
      endcase
      res.busy_res = nxt.in_flight;
   end

   assign result     = res;
   assign next_state = nxt;

endmodule

`default_nettype wire

/* src/battery_pack_discharge_selector_top.sv */
// ----------------------------------------------------------------------------
// battery_pack_discharge_selector_top
// Picks which battery pack feeds the load and issues controller commands.
//
//   channel | direction | handshake           | carries
//   req     | in        | req_valid/req_ready | op and pack snapshot
//   rsp     | out       | rsp_valid/rsp_ready | status, command, event, busy
//   csr     | in        | csr_write_enable    | register index and data
//
// One item per cycle sustained while rsp_ready stays high. An item goes
// through the input register, then the decision logic into the result
// register. The control state updates in the cycle an item passes the
// decision logic.
// A stalled result holds the pipe: the input register keeps its item and
// req_ready drops only when both stages are full and rsp_ready is low.
// Synchronous reset sets register defaults and clears valid and control state.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_pack_discharge_selector_top #(
   parameter int PACK_COUNT = 3
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // item in
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_op,
   input  wire logic [1:0]         req_pack_id,
   input  wire logic               req_success,
   input  wire logic [2:0]         req_state_a,
   input  wire logic [2:0]         req_state_b,
   input  wire logic [2:0]         req_state_c,
   input  wire logic [15:0]        req_vol_a,
   input  wire logic [15:0]        req_vol_b,
   input  wire logic [15:0]        req_vol_c,
   input  wire logic signed [15:0] req_cur_a,
   input  wire logic signed [15:0] req_cur_b,
   input  wire logic signed [15:0] req_cur_c,
   // result out
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [2:0]              rsp_cmd,
   output logic [1:0]              rsp_cmd_pack,
   output logic [1:0]              rsp_event_res,
   output logic [1:0]              rsp_event_pack,
   output logic [1:0]              rsp_discharging_count,
   output logic                    rsp_busy_res,
   // register writes
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);
   import bpds_pkg::*;

`include "battery_pack_discharge_selector_top_macros.svh"

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MIN_VOLT_DIFF: cfg_in.min_volt_diff         = csr_wdata;
            CSR_MIN_DIS_CUR:   cfg_in.min_discharge_current = csr_wdata;
            CSR_PORT_MASK:     cfg_in.port_enable_mask      = csr_wdata[2:0];
            CSR_SWITCH_EN:     cfg_in.switch_enable         = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_volt_diff         <= 16'd500;
         cfg_ff.min_discharge_current <= 16'd1000;
         cfg_ff.port_enable_mask      <= 3'b111;
         cfg_ff.switch_enable         <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipe control
   logic req_fire;
   logic dec_fire;
   logic out_free;
   logic in_valid_ff, in_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign dec_fire  = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in  = req_fire ? 1'b1 : (dec_fire ? 1'b0 : in_valid_ff);
      rsp_valid_in = dec_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register
   req_item_type item_ff, item_in;

   always_comb begin
      item_in.op      = op_type'(req_op);
      item_in.pack_id = req_pack_id;
      item_in.success = req_success;
      item_in.state_a = req_state_a;
      item_in.state_b = req_state_b;
      item_in.state_c = req_state_c;
      item_in.vol_a   = req_vol_a;
      item_in.vol_b   = req_vol_b;
      item_in.vol_c   = req_vol_c;
      item_in.cur_a   = req_cur_a;
      item_in.cur_b   = req_cur_b;
      item_in.cur_c   = req_cur_c;
   end

   always_ff @(posedge clock) begin
      if (req_fire) item_ff <= item_in;
   end

   // decision logic
   ctl_state_type state_ff, state_next;
   rsp_item_type  result;

   bpds_core #(
      .PACK_COUNT (PACK_COUNT)
   ) u_core (
      .item       (item_ff),
      .cur_state  (state_ff),
      .cfg        (cfg_ff),
      .result     (result),
      .next_state (state_next)
   );

   // control state
   ctl_state_type state_in;

   assign state_in = dec_fire ? state_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.paused       <= 1'b0;
         state_ff.in_flight    <= 1'b0;
         state_ff.forced_valid <= 1'b0;
         state_ff.forced_pack  <= 2'd0;
         state_ff.pending_kind <= PEND_MOVE;
      end else begin
         state_ff <= state_in;
      end
   end

   // result register
   rsp_item_type rsp_ff;

   always_ff @(posedge clock) begin
      if (dec_fire) rsp_ff <= result;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_ff.status;
   assign rsp_cmd               = rsp_ff.cmd;
   assign rsp_cmd_pack          = rsp_ff.cmd_pack;
   assign rsp_event_res         = rsp_ff.event_res;
   assign rsp_event_pack        = rsp_ff.event_pack;
   assign rsp_discharging_count = rsp_ff.discharging_count;
   assign rsp_busy_res          = rsp_ff.busy_res;

   // checks
   // a pause leaves the block paused with no command outstanding
   `BPDS_ASSERT_NEXT(a_pause_sets, clock, reset, dec_fire && item_ff.op == OP_PAUSE, state_ff.paused && !state_ff.in_flight)
   // any controller command other than release marks the controller busy
   `BPDS_ASSERT_SAME(a_cmd_busy, clock, reset, rsp_valid_ff && (rsp_ff.cmd == CMD_SWITCH || rsp_ff.cmd == CMD_MERGE || rsp_ff.cmd == CMD_POWER_OFF), rsp_ff.busy_res)
   // a held forced pack always names a real pack
   `BPDS_ASSERT_SAME(a_forced_range, clock, reset, state_ff.forced_valid, 32'(state_ff.forced_pack) < PACK_COUNT)
   // a refused process step leaves the forced selection alone
   `BPDS_ASSERT_NEXT(a_refused_hold, clock, reset, dec_fire && result.status == STS_PAUSED, $stable(state_ff.forced_valid) && $stable(state_ff.forced_pack))

endmodule

`default_nettype wire
